### rtl/lprr_pkg.sv
// Package: shared constants and types for the lease pool selector.
`timescale 1ns / 1ps
package lprr_pkg;
  localparam int SLOTS = 16;
  localparam int SLOT_W = 4;
  localparam int CNT_W = 5;
  localparam logic [15:0] LEASE_RESET = 16'd30;

  typedef enum logic [3:0] {
    OP_TICK      = 4'd0,
    OP_HEARTBEAT = 4'd1,
    OP_REMOVE    = 4'd2,
    OP_SET_LOAD  = 4'd3,
    OP_SELECT    = 4'd4,
    OP_SELECT_K  = 4'd5,
    OP_LEAST     = 4'd6,
    OP_LIST      = 4'd7,
    OP_COUNT     = 4'd8
  } op_t;

  localparam logic [1:0] ROLE_PREFILL = 2'd0;
  localparam logic [1:0] ROLE_DECODE = 2'd1;
endpackage

### rtl/lprr_outreg.sv
// Module: one-entry output register holding a result item.
`timescale 1ns / 1ps
module lprr_outreg (
  input  logic        clk,
  input  logic        rst,
  input  logic        load_en,
  input  logic        d_found,
  input  logic [3:0]  d_slot,
  input  logic        d_role,
  input  logic [15:0] d_load,
  input  logic [5:0]  d_total,
  input  logic        d_last,
  output logic        full,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic [3:0]  out_slot,
  output logic        out_role,
  output logic [15:0] out_load,
  output logic [5:0]  live_total,
  output logic        last
);
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (load_en) begin
      found <= d_found;
      out_slot <= d_slot;
      out_role <= d_role;
      out_load <= d_load;
      live_total <= d_total;
      last <= d_last;
    end
  end
  assign full = out_valid && !out_ready;
endmodule

### rtl/lease_pool_round_robin_selector.sv
// Top level: lease pool round-robin selector with per-slot sweep sequencer.
// Keeps prefill and decode pools of 16 worker slots, each slot with a live bit, a lease deadline
// and a load, plus one round-robin pointer per pool. lease_ticks is the one APB register, at
// address 0. The block takes one item at a time, and in_ready is high only in idle. A small
// sequencer drives a deadline compare per pool, one load compare and one compare-and-subtract
// unit, one slot per cycle while the output register is not full. Tick, remove and set_load
// finish in the accepting cycle. Count goes from the accept straight to the answer state.
// Heartbeat accepts, sweeps all 16 slots and then registers the new lease. The lowest-load
// query accepts, sweeps, scans the 16 decode slots and then answers. Select, select_k and list
// accept, sweep and count the live slots of the pool, then take the pointer modulo the live
// count and walk the pool to emit the rows; the walk holds while the one-entry output
// register stays full. Select ops on a role above 1 answer right after the sweep.
`timescale 1ns / 1ps
module lease_pool_round_robin_selector (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  op,
  input  logic [1:0]  role,
  input  logic [3:0]  slot,
  input  logic [15:0] new_load,
  input  logic [4:0]  want_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic [3:0]  out_slot,
  output logic        out_role,
  output logic [15:0] out_load,
  output logic [5:0]  live_total,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SWEEP = 7'b0000010,
    S_REG   = 7'b0000100,
    S_COUNT = 7'b0001000,
    S_MOD   = 7'b0010000,
    S_WALK  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic [15:0] lease_ticks;
  logic [31:0] now_time;
  logic [lprr_pkg::SLOTS-1:0] p_live, d_live;
  logic [31:0] p_dl [lprr_pkg::SLOTS];
  logic [31:0] d_dl [lprr_pkg::SLOTS];
  logic [15:0] p_wt [lprr_pkg::SLOTS];
  logic [15:0] d_wt [lprr_pkg::SLOTS];
  logic [3:0] p_ptr, d_ptr;

  logic [3:0] r_op;
  logic [1:0] r_role;
  logic [3:0] r_slot;
  logic [4:0] r_want;
  logic [3:0] idx;         // walk position
  logic [4:0] n;           // live count in pool
  logic [4:0] skip;        // live entries to skip before first row
  logic [4:0] emitted;     // rows emitted
  logic [4:0] k;           // rows to emit
  logic [4:0] rem;         // pointer modulo n
  logic [3:0] best_slot;
  logic [15:0] best_wt;
  logic best_found;

  logic ld;
  logic d_found, d_role, d_last;
  logic [3:0] d_slot;
  logic [15:0] d_loadv;
  logic [5:0] d_total;
  logic obuf_full;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {16'd0, lease_ticks} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) begin
      lease_ticks <= lprr_pkg::LEASE_RESET;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      lease_ticks <= pwdata[15:0];
    end
  end

  assign in_ready = (state == S_IDLE);
  wire accept = in_valid && in_ready;
  wire use_d = r_role[0];
  wire live_i = use_d ? d_live[idx] : p_live[idx];
  wire [15:0] wt_i = use_d ? d_wt[idx] : p_wt[idx];
  wire [31:0] p_diff = p_dl[idx] - now_time;
  wire [31:0] d_diff = d_dl[idx] - now_time;
  wire is_sel = r_op == lprr_pkg::OP_SELECT || r_op == lprr_pkg::OP_SELECT_K
                || r_op == lprr_pkg::OP_LIST;
  wire wrap = idx == 4'(lprr_pkg::SLOTS - 1);
  wire [4:0] n_inc = n + {4'd0, live_i};
  wire [3:0] ptr_sel = use_d ? d_ptr : p_ptr;
  wire [4:0] rem_inc = rem + 5'd1;
  wire [4:0] k_sel = (r_want < n) ? r_want : n;
  wire [4:0] base = (r_op == lprr_pkg::OP_SELECT) ? {1'b0, ptr_sel} + 5'd1
                  : (r_op == lprr_pkg::OP_SELECT_K) ? {1'b0, ptr_sel} : 5'd0;

  // combined live count for count op
  logic [5:0] total;
  always_comb begin
    total = '0;
    for (int j = 0; j < lprr_pkg::SLOTS; j++)
      total = total + 6'(p_live[j]) + 6'(d_live[j]);
  end

  always_comb begin
    state_next = state;
    ld = 1'b0;
    d_found = 1'b0;
    d_slot = '0;
    d_role = 1'b0;
    d_loadv = '0;
    d_total = '0;
    d_last = 1'b1;
    case (state)
      S_IDLE: if (accept) begin
        case (op)
          lprr_pkg::OP_HEARTBEAT, lprr_pkg::OP_SELECT, lprr_pkg::OP_SELECT_K,
          lprr_pkg::OP_LEAST, lprr_pkg::OP_LIST: state_next = S_SWEEP;
          lprr_pkg::OP_COUNT: state_next = S_DONE;
          default: state_next = S_IDLE;
        endcase
      end
      S_SWEEP: if (wrap) begin
        if (r_op == lprr_pkg::OP_HEARTBEAT) state_next = S_REG;
        else if (is_sel && r_role[1]) state_next = S_DONE;
        else state_next = S_COUNT;
      end
      S_REG: state_next = S_IDLE;
      S_COUNT: if (wrap) begin
        if (r_op == lprr_pkg::OP_LEAST || n_inc == 5'd0) state_next = S_DONE;
        else state_next = S_MOD;
      end
      S_MOD: if (rem < n) begin
        if (r_op == lprr_pkg::OP_SELECT_K && r_want == 5'd0) state_next = S_DONE;
        else state_next = S_WALK;
      end
      S_WALK: if (live_i && skip == 5'd0 && !obuf_full) begin
        ld = 1'b1;
        d_found = 1'b1;
        d_slot = idx;
        d_role = use_d;
        d_loadv = wt_i;
        d_last = (emitted + 5'd1 == k);
        if (d_last) state_next = S_IDLE;
      end
      S_DONE: if (!obuf_full) begin
        ld = 1'b1;
        state_next = S_IDLE;
        if (r_op == lprr_pkg::OP_COUNT) begin
          d_total = total;
        end else if (r_op == lprr_pkg::OP_LEAST && best_found) begin
          d_found = 1'b1;
          d_slot = best_slot;
          d_role = 1'b1;
          d_loadv = best_wt;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      now_time <= '0;
      p_live <= '0;
      d_live <= '0;
      p_ptr <= '0;
      d_ptr <= '0;
      idx <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: if (accept) begin
          r_op <= op; r_role <= role; r_slot <= slot; r_want <= want_count;
          idx <= '0;
          case (op)
            lprr_pkg::OP_TICK: now_time <= now_time + 32'd1;
            lprr_pkg::OP_REMOVE: begin
              p_live[slot] <= 1'b0;
              d_live[slot] <= 1'b0;
            end
            lprr_pkg::OP_SET_LOAD: begin
              if (p_live[slot]) p_wt[slot] <= new_load;
              else if (d_live[slot]) d_wt[slot] <= new_load;
            end
            default: ;
          endcase
        end
        S_SWEEP: begin
          if (p_live[idx] && p_diff[31]) p_live[idx] <= 1'b0;
          if (d_live[idx] && d_diff[31]) d_live[idx] <= 1'b0;
          n <= '0;
          best_found <= 1'b0;
          idx <= idx + 4'd1;
        end
        S_REG: begin
          if (r_role == lprr_pkg::ROLE_PREFILL) begin
            p_live[r_slot] <= 1'b1;
            p_dl[r_slot] <= now_time + {16'd0, lease_ticks};
            p_wt[r_slot] <= '0;
          end else if (r_role == lprr_pkg::ROLE_DECODE) begin
            d_live[r_slot] <= 1'b1;
            d_dl[r_slot] <= now_time + {16'd0, lease_ticks};
            d_wt[r_slot] <= '0;
          end
        end
        S_COUNT: begin
          if (r_op == lprr_pkg::OP_LEAST) begin
            if (d_live[idx] && (!best_found || d_wt[idx] < best_wt)) begin
              best_found <= 1'b1;
              best_slot <= idx;
              best_wt <= d_wt[idx];
            end
          end else begin
            n <= n_inc;
          end
          if (wrap) rem <= base;
          idx <= idx + 4'd1;
        end
        S_MOD: begin
          if (rem >= n) begin
            rem <= rem - n;
          end else begin
            skip <= rem;
            emitted <= '0;
            case (r_op)
              lprr_pkg::OP_SELECT: begin
                if (use_d) d_ptr <= rem[3:0];
                else p_ptr <= rem[3:0];
                k <= 5'd1;
              end
              lprr_pkg::OP_SELECT_K: begin
                if (use_d) d_ptr <= (rem_inc == n) ? 4'd0 : rem_inc[3:0];
                else p_ptr <= (rem_inc == n) ? 4'd0 : rem_inc[3:0];
                k <= k_sel;
              end
              default: k <= n;
            endcase
          end
        end
        S_WALK: begin
          if (!live_i) begin
            idx <= idx + 4'd1;
          end else if (skip != 5'd0) begin
            skip <= skip - 5'd1;
            idx <= idx + 4'd1;
          end else if (!obuf_full) begin
            emitted <= emitted + 5'd1;
            idx <= idx + 4'd1;
          end
        end
        default: ;
      endcase
    end
  end

  lprr_outreg u_out (
    .clk(clk), .rst(rst), .load_en(ld),
    .d_found(d_found), .d_slot(d_slot), .d_role(d_role), .d_load(d_loadv),
    .d_total(d_total), .d_last(d_last), .full(obuf_full),
    .out_valid(out_valid), .out_ready(out_ready), .found(found),
    .out_slot(out_slot), .out_role(out_role), .out_load(out_load),
    .live_total(live_total), .last(last)
  );

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("accept while busy");
  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state)) else $error("state not one-hot");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("row lost");
  a_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
    $stable({found, out_slot, out_role, out_load, live_total, last}))
    else $error("row changed while waiting");
`endif
endmodule

### tb/lease_pool_round_robin_selector_tb.sv
// Testbench: lease pool selector, directed and random items checked against a predictor.
`timescale 1ns / 1ps
module lease_pool_round_robin_selector_tb;
  typedef struct packed {
    logic        found;
    logic [3:0]  slot;
    logic        role;
    logic [15:0] load;
    logic [5:0]  total;
    logic        last;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  op = '0;
  logic [1:0]  role = '0;
  logic [3:0]  slot = '0;
  logic [15:0] new_load = '0;
  logic [4:0]  want_count = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        found;
  logic [3:0]  out_slot;
  logic        out_role;
  logic [15:0] out_load;
  logic [5:0]  live_total;
  logic        last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  lease_pool_round_robin_selector i_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [15:0] lease_q;
  logic [31:0] now_q;
  logic [15:0] pf_live, dc_live;
  logic [31:0] pf_dl [lprr_pkg::SLOTS];
  logic [31:0] dc_dl [lprr_pkg::SLOTS];
  logic [15:0] pf_wt [lprr_pkg::SLOTS];
  logic [15:0] dc_wt [lprr_pkg::SLOTS];
  logic [3:0]  pf_ptr, dc_ptr;

  row_t pending_rows[$];
  int   mismatches = 0;
  int   idle_cycles = 0;
  bit   hold_req = 1'b0;
  bit   timed_out = 1'b0;

  function automatic bit expired(logic [31:0] dl);
    logic [31:0] d;
    d = dl - now_q;
    return d[31];
  endfunction

  function automatic void sweep_pools();
    for (int i = 0; i < lprr_pkg::SLOTS; i++) begin
      if (pf_live[i] && expired(pf_dl[i])) pf_live[i] = 1'b0;
      if (dc_live[i] && expired(dc_dl[i])) dc_live[i] = 1'b0;
    end
  endfunction

  function automatic row_t mk_row(bit f, int s, bit r, logic [15:0] l, int t, bit lst);
    row_t x;
    x.found = f;
    x.slot = s[3:0];
    x.role = r;
    x.load = l;
    x.total = t[5:0];
    x.last = lst;
    return x;
  endfunction

  function automatic void queue_row(row_t r);
    pending_rows.insert(pending_rows.size(), r);
  endfunction

  function automatic void predict_pool_op(logic [3:0] o, logic [1:0] rl, logic [3:0] s,
                                          logic [15:0] ld, logic [4:0] want);
    int idx[lprr_pkg::SLOTS];
    int n, k, start, best, cnt;
    logic [15:0] lv;
    logic [3:0] p;
    n = 0;
    case (o)
      lprr_pkg::OP_TICK: now_q = now_q + 32'd1;
      lprr_pkg::OP_HEARTBEAT: begin
        sweep_pools();
        if (rl == lprr_pkg::ROLE_PREFILL) begin
          pf_live[s] = 1'b1; pf_dl[s] = now_q + {16'd0, lease_q}; pf_wt[s] = '0;
        end else if (rl == lprr_pkg::ROLE_DECODE) begin
          dc_live[s] = 1'b1; dc_dl[s] = now_q + {16'd0, lease_q}; dc_wt[s] = '0;
        end
      end
      lprr_pkg::OP_REMOVE: begin
        pf_live[s] = 1'b0;
        dc_live[s] = 1'b0;
      end
      lprr_pkg::OP_SET_LOAD: begin
        if (pf_live[s]) pf_wt[s] = ld;
        else if (dc_live[s]) dc_wt[s] = ld;
      end
      lprr_pkg::OP_SELECT, lprr_pkg::OP_SELECT_K, lprr_pkg::OP_LIST: begin
        sweep_pools();
        if (rl > lprr_pkg::ROLE_DECODE) begin
          queue_row(mk_row(0, 0, 0, '0, 0, 1));
        end else begin
          lv = (rl == lprr_pkg::ROLE_DECODE) ? dc_live : pf_live;
          p = (rl == lprr_pkg::ROLE_DECODE) ? dc_ptr : pf_ptr;
          for (int i = 0; i < lprr_pkg::SLOTS; i++) if (lv[i]) idx[n++] = i;
          if (n == 0) begin
            queue_row(mk_row(0, 0, 0, '0, 0, 1));
          end else if (o == lprr_pkg::OP_SELECT) begin
            p = 4'((int'(p) + 1) % n);
            queue_row(mk_row(1, idx[p], rl[0],
              rl[0] ? dc_wt[idx[p]] : pf_wt[idx[p]], 0, 1));
          end else if (o == lprr_pkg::OP_SELECT_K) begin
            k = (int'(want) < n) ? int'(want) : n;
            start = int'(p);
            p = 4'((start + 1) % n);
            if (k == 0) queue_row(mk_row(0, 0, 0, '0, 0, 1));
            for (int i = 0; i < k; i++) begin
              best = idx[(start + i) % n];
              queue_row(mk_row(1, best, rl[0],
                rl[0] ? dc_wt[best] : pf_wt[best], 0, i + 1 == k));
            end
          end else begin
            for (int i = 0; i < n; i++)
              queue_row(mk_row(1, idx[i], rl[0],
                rl[0] ? dc_wt[idx[i]] : pf_wt[idx[i]], 0, i + 1 == n));
          end
          if (rl == lprr_pkg::ROLE_DECODE) dc_ptr = p;
          else pf_ptr = p;
        end
      end
      lprr_pkg::OP_LEAST: begin
        sweep_pools();
        best = -1;
        for (int i = 0; i < lprr_pkg::SLOTS; i++)
          if (dc_live[i] && (best < 0 || dc_wt[i] < dc_wt[best])) best = i;
        if (best < 0) queue_row(mk_row(0, 0, 0, '0, 0, 1));
        else queue_row(mk_row(1, best, 1, dc_wt[best], 0, 1));
      end
      lprr_pkg::OP_COUNT: begin
        cnt = $countones(pf_live) + $countones(dc_live);
        queue_row(mk_row(0, 0, 0, '0, cnt, 1));
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(logic [3:0] o, logic [1:0] rl, logic [3:0] s,
                           logic [15:0] ld, logic [4:0] want);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 19));
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    op <= o; role <= rl; slot <= s; new_load <= ld; want_count <= want;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_pool_op(o, rl, s, ld, want);
  endtask

  task automatic write_lease(logic [15:0] val);
    paddr <= 2'd0; pwdata <= {16'd0, val}; pwrite <= 1'b1; psel <= 1'b1; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    lease_q = val;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain_rows();
    in_valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // checker
  always @(posedge clk) begin
    row_t got, want_r;
    if (!rst && out_valid && out_ready) begin
      got = mk_row(found, out_slot, out_role, out_load, live_total, last);
      if (pending_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want_r = pending_rows.pop_front();
        if (got !== want_r) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want_r, got);
        end
      end
    end
  end

  // receiver
  initial begin
    int w;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        w = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 19));
        if (w == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          repeat (w) @(posedge clk);
          out_ready <= 1'b1;
        end
        @(posedge clk);
        while (!(out_valid && out_ready) && !hold_req) @(posedge clk);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000 && !timed_out) begin
      timed_out = 1'b1;
      $display("Verification failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(lprr_pkg::OP_COUNT, 2'd0, 4'd0, 16'd0, 5'd0);
    send_item(lprr_pkg::OP_SELECT, lprr_pkg::ROLE_PREFILL, 4'd0, 16'd0, 5'd0);
    send_item(lprr_pkg::OP_LEAST, 2'd0, 4'd0, 16'd0, 5'd0);
    send_item(lprr_pkg::OP_LIST, lprr_pkg::ROLE_DECODE, 4'd0, 16'd0, 5'd0);
    send_item(lprr_pkg::OP_HEARTBEAT, lprr_pkg::ROLE_PREFILL, 4'd0, 16'd0, 5'd0);
    send_item(lprr_pkg::OP_HEARTBEAT, lprr_pkg::ROLE_PREFILL, 4'd15, 16'd0, 5'd0);
    send_item(lprr_pkg::OP_HEARTBEAT, lprr_pkg::ROLE_DECODE, 4'd3, 16'd0, 5'd0);
    send_item(lprr_pkg::OP_HEARTBEAT, lprr_pkg::ROLE_DECODE, 4'd9, 16'd0, 5'd0);
    send_item(lprr_pkg::OP_HEARTBEAT, 2'd2, 4'd5, 16'd0, 5'd0);
    send_item(lprr_pkg::OP_SET_LOAD, 2'd0, 4'd15, 16'hFFFF, 5'd0);
    send_item(lprr_pkg::OP_SET_LOAD, 2'd0, 4'd3, 16'h0000, 5'd0);
    send_item(lprr_pkg::OP_SET_LOAD, 2'd0, 4'd9, 16'h0000, 5'd0);
    send_item(lprr_pkg::OP_LEAST, 2'd3, 4'd0, 16'd0, 5'd0);
    send_item(lprr_pkg::OP_SELECT_K, lprr_pkg::ROLE_PREFILL, 4'd0, 16'd0, 5'd0);
    send_item(lprr_pkg::OP_SELECT_K, lprr_pkg::ROLE_PREFILL, 4'd0, 16'd0, 5'd16);
    send_item(lprr_pkg::OP_SELECT_K, 2'd3, 4'd0, 16'd0, 5'd16);
    send_item(lprr_pkg::OP_SELECT, 2'd2, 4'd0, 16'd0, 5'd0);
    send_item(lprr_pkg::OP_LIST, lprr_pkg::ROLE_PREFILL, 4'd0, 16'd0, 5'd0);
    send_item(4'd9, 2'd0, 4'd0, 16'd0, 5'd0);
    send_item(4'd15, 2'd3, 4'd15, 16'hFFFF, 5'd31);
    send_item(lprr_pkg::OP_REMOVE, 2'd0, 4'd0, 16'd0, 5'd0);
    send_item(lprr_pkg::OP_COUNT, 2'd3, 4'd0, 16'd0, 5'd0);
    drain_rows();
  endtask

  task automatic test_expiry();
    write_lease(16'd1);
    send_item(lprr_pkg::OP_HEARTBEAT, lprr_pkg::ROLE_DECODE, 4'd7, 16'd0, 5'd0);
    send_item(lprr_pkg::OP_TICK, 2'd0, 4'd0, 16'd0, 5'd0);
    send_item(lprr_pkg::OP_LIST, lprr_pkg::ROLE_DECODE, 4'd0, 16'd0, 5'd0);
    send_item(lprr_pkg::OP_TICK, 2'd0, 4'd0, 16'd0, 5'd0);
    send_item(lprr_pkg::OP_LIST, lprr_pkg::ROLE_DECODE, 4'd0, 16'd0, 5'd0);
    send_item(lprr_pkg::OP_COUNT, 2'd0, 4'd0, 16'd0, 5'd0);
    drain_rows();
    write_lease(16'hFFFF);
    drain_rows();
  endtask

  task automatic test_fill_all();
    for (int i = 0; i < lprr_pkg::SLOTS; i++)
      send_item(lprr_pkg::OP_HEARTBEAT, lprr_pkg::ROLE_DECODE, i[3:0], 16'd0, 5'd0);
    for (int i = 0; i < lprr_pkg::SLOTS; i++)
      send_item(lprr_pkg::OP_HEARTBEAT, lprr_pkg::ROLE_PREFILL, i[3:0], 16'd0, 5'd0);
    hold_req = 1'b1;
    send_item(lprr_pkg::OP_LIST, lprr_pkg::ROLE_DECODE, 4'd0, 16'd0, 5'd0);
    send_item(lprr_pkg::OP_SELECT_K, lprr_pkg::ROLE_PREFILL, 4'd0, 16'd0, 5'd31);
    send_item(lprr_pkg::OP_COUNT, 2'd0, 4'd0, 16'd0, 5'd0);
    drain_rows();
  endtask

  task automatic test_random();
    logic [3:0] o;
    logic [1:0] rl;
    int r;
    write_lease(16'd30);
    for (int i = 0; i < 40; i++) begin
      r = $urandom_range(0, 99);
      if (r < 20) o = lprr_pkg::OP_HEARTBEAT;
      else if (r < 30) o = lprr_pkg::OP_TICK;
      else if (r < 37) o = lprr_pkg::OP_REMOVE;
      else if (r < 50) o = lprr_pkg::OP_SET_LOAD;
      else if (r < 62) o = lprr_pkg::OP_SELECT;
      else if (r < 74) o = lprr_pkg::OP_SELECT_K;
      else if (r < 82) o = lprr_pkg::OP_LEAST;
      else if (r < 90) o = lprr_pkg::OP_LIST;
      else if (r < 97) o = lprr_pkg::OP_COUNT;
      else o = 4'($urandom_range(9, 15));
      rl = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
      send_item(o, rl, 4'($urandom_range(0, 15)), 16'($urandom), 5'($urandom_range(0, 31)));
      if (i == 20) begin
        drain_rows();
        write_lease(16'($urandom_range(2, 8)));
      end
    end
    drain_rows();
  endtask

  initial begin
    lease_q = lprr_pkg::LEASE_RESET;
    now_q = '0;
    pf_live = '0; dc_live = '0;
    pf_ptr = '0; dc_ptr = '0;
    for (int i = 0; i < lprr_pkg::SLOTS; i++) begin
      pf_dl[i] = '0; dc_dl[i] = '0; pf_wt[i] = '0; dc_wt[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_expiry();
    test_fill_all();
    test_random();
    if (mismatches == 0 && pending_rows.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

### filelist.f
rtl/lprr_pkg.sv
rtl/lprr_outreg.sv
rtl/lease_pool_round_robin_selector.sv
tb/lease_pool_round_robin_selector_tb.sv
